[rtl/cdp_pkg.sv]
// Shared types, constants and the decode term mask table for the decode PLA.
`timescale 1ns / 1ps
package cdp_pkg;

    localparam int TERM_COUNT = 128;
    localparam int COL_COUNT  = 21;

    // Lines with extra kill conditions
    localparam int LINE_BRANCH_READY = 73;
    localparam int LINE_EXCL_A       = 83;
    localparam int LINE_EXCL_B       = 90;

    typedef logic [COL_COUNT-1:0]  t_cols;
    typedef logic [TERM_COUNT-1:0] t_lines;

    // Column conditions plus the two implied-opcode detectors.
    // t_cols bit 20 is column 0 (T!=1), bit 0 is column 20 (T!=5).
    typedef struct packed {
        t_cols cols;
        logic  push_pull;
        logic  implied;
        logic  not_ready;
    } t_dec_ctrl;

    // Term masks: a set bit blocks the term while its column condition holds.
    localparam t_cols TERM_MASK [TERM_COUNT] = '{
        21'b000101100000100100000, 21'b000000010110001000100,
        21'b000000011010001001000, 21'b010100011001100100000,
        21'b010101011010100100000, 21'b010110000001100100000,
        21'b000000100010000001000, 21'b000001000000100010000,
        21'b000000010101001001000, 21'b010101011001100010000,
        21'b010110011001100010000, 21'b011010000001100100000,
        21'b000101000000100010000, 21'b010101011010100010000,
        21'b011001000000100010000, 21'b100110011001100010000,
        21'b101010011001100100000, 21'b011001011010100010000,
        21'b100100011001100100000, 21'b011001100000100100000,
        21'b011001000001100100000, 21'b011001010101010100000,
        21'b000101010101010100001, 21'b010100011001010100000,
        21'b001010010101010100010, 21'b001000011001010100100,
        21'b000110010101010100001, 21'b001010000000010010000,
        21'b000000000000000001000, 21'b010110000000011000000,
        21'b000010101001010100000, 21'b000000101001000001000,
        21'b010101000000011000000, 21'b000000000100000001000,
        21'b010000000000000000000, 21'b000000010001010101000,
        21'b000000000001010100100, 21'b000001010101010100010,
        21'b000110010101010100010, 21'b000000010101001000100,
        21'b000000010110001000010, 21'b000000010110001001000,
        21'b000000001010000000100, 21'b001000011001010100000,
        21'b001010000000100010000, 21'b000000010101001000010,
        21'b000000010110001000100, 21'b000010010101010100000,
        21'b001001010101010101000, 21'b010010000001100100000,
        21'b010110000000101000000, 21'b011010000000101000000,
        21'b011010000000001000000, 21'b001001000000010010000,
        21'b000010101001010100100, 21'b000001000000010010000,
        21'b001001010101010100001, 21'b000000010001010101000,
        21'b010101011010100100000, 21'b100000000000011000000,
        21'b101010000000001000000, 21'b100000011001010010000,
        21'b010101011001100010000, 21'b011010011001010100000,
        21'b011001000000101000000, 21'b010000000000001000000,
        21'b011001011001100100000, 21'b010000011001010010000,
        21'b011001011001100010000, 21'b011001100001010100000,
        21'b011001000000011000000, 21'b000000001010000000010,
        21'b000000010110001000001, 21'b010000010110000100000,
        21'b000110011001010101000, 21'b010010011001010010000,
        21'b000010000000010010000, 21'b000101010101010101000,
        21'b001001010101010100100, 21'b000101000000101000000,
        21'b000000010110000101000, 21'b000000100100000001000,
        21'b000000010100001001000, 21'b000000001000000001000,
        21'b001010010101010100001, 21'b000000000000000000010,
        21'b000000000000000000100, 21'b010100010101010100000,
        21'b010010101001010100000, 21'b000000010101001000001,
        21'b000000001000000000100, 21'b000000010110001000010,
        21'b000000001010000000100, 21'b000000010110000100100,
        21'b000100010101010100000, 21'b001001010101010100000,
        21'b000010101001010100000, 21'b000101000000100000000,
        21'b000101010101010100010, 21'b000101011001010101000,
        21'b000100011001010101000, 21'b000010101001010100010,
        21'b000010010101010100001, 21'b001001010101010100001,
        21'b000110101001010101000, 21'b001000011001010100100,
        21'b000010000000000010000, 21'b000001000000010010000,
        21'b010010011010010100000, 21'b101001100001010100000,
        21'b010001011010010100000, 21'b000000100110000000100,
        21'b101010000000001000000, 21'b011001100001010100000,
        21'b011001011001010100000, 21'b000110010101010100010,
        21'b100110000000101000000, 21'b100010101001100100000,
        21'b100001011001010010000, 21'b100010000101100100000,
        21'b010010011010100100000, 21'b000001000000000000000,
        21'b000000101001000000100, 21'b000000100101000001000,
        21'b000000010100001000001, 21'b000000001010000000010,
        21'b000000000000010000000, 21'b001001011010100100000
    };

endpackage

[rtl/cdp_col_gen.sv]
// Column condition generator: opcode bit levels, timing step inequality tests, push/pull detect.
`timescale 1ns / 1ps
module cdp_col_gen (
    input  logic [7:0]        i_ir,
    input  logic [2:0]        i_step,
    input  logic              i_not_ready,
    output cdp_pkg::t_dec_ctrl o_ctrl
);
    import cdp_pkg::*;

    logic ir01;
    logic push_pull;

    // IR0 or IR1 feeds both a column and the detectors
    assign ir01 = i_ir[0] | i_ir[1];

    // Push/pull: 0XX01000
    assign push_pull = ~(i_ir[2] | ~i_ir[3] | i_ir[4] | i_ir[7] | ir01);

    always_comb begin
        o_ctrl.cols = {
            (i_step != 3'd1), (i_step != 3'd0),
            ~i_ir[5], i_ir[5],
            ~i_ir[6], i_ir[6],
            ~i_ir[2], i_ir[2],
            ~i_ir[3], i_ir[3],
            ~i_ir[4], i_ir[4],
            ~i_ir[7], i_ir[7],
            ~i_ir[0], ir01, ~i_ir[1],
            (i_step != 3'd2), (i_step != 3'd3),
            (i_step != 3'd4), (i_step != 3'd5)
        };
        o_ctrl.push_pull = push_pull;
        // Implied opcodes XXXX10X0, push/pull excluded
        o_ctrl.implied   = ~(i_ir[2] | ~i_ir[3] | i_ir[0] | push_pull);
        o_ctrl.not_ready = i_not_ready;
    end

endmodule

[rtl/cdp_term_array.sv]
// Product-term array: 128 masked NOR terms with the branch and push/pull kills.
`timescale 1ns / 1ps
module cdp_term_array (
    input  cdp_pkg::t_dec_ctrl i_ctrl,
    output cdp_pkg::t_lines    o_lines
);
    import cdp_pkg::*;

    t_lines terms;

    // A term fires when none of its marked columns is active
    always_comb begin
        for (int n = 0; n < TERM_COUNT; n++) begin
            terms[n] = ~|(TERM_MASK[n] & i_ctrl.cols);
        end
    end

    // Extra kills on the branch-ready line and the two push/pull exclusions
    always_comb begin
        o_lines = terms;
        o_lines[LINE_BRANCH_READY] = terms[LINE_BRANCH_READY] & ~i_ctrl.not_ready;
        o_lines[LINE_EXCL_A]       = terms[LINE_EXCL_A] & ~i_ctrl.push_pull;
        o_lines[LINE_EXCL_B]       = terms[LINE_EXCL_B] & ~i_ctrl.push_pull;
    end

endmodule

[rtl/cpu_decode_pla.sv]
// Top level of the instruction decode PLA: input register, decode logic, result register.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one item: opcode byte, timing
//   step and the previous-not-ready flag. An item is taken at an edge where
//   i_valid is high and o_stall is low.
//   Output channel (o_valid / i_stall) carries the 130 decode lines as four
//   32-bit words plus the implied and push/pull lines.
//   An item taken is held in the input register, decoded through one level
//   of PLA logic, and then registered in the result register that drives the
//   outputs. Throughput: one item per clock while the receiver keeps up.
//   When the receiver stalls, the result register holds its item unchanged
//   and the input register can still take one more item; o_stall rises
//   only once both registers are full and the result is stalled.
//   Reset (i_rst_n low, synchronous) empties both registers, dropping any
//   items they hold; no item is invented since the block has no other state.
`timescale 1ns / 1ps
module cpu_decode_pla (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_instr_byte,
    input  logic [2:0]  i_timing_step,
    input  logic        i_prev_not_ready,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_lines_0_31,
    output logic [31:0] o_lines_32_63,
    output logic [31:0] o_lines_64_95,
    output logic [31:0] o_lines_96_127,
    output logic        o_implied_line,
    output logic        o_push_pull_line
);
    import cdp_pkg::*;

    logic      r_in_valid;
    logic      n_in_valid;
    logic [7:0] r_ir;
    logic [2:0] r_step;
    logic      r_not_ready;

    logic      r_out_valid;
    logic      n_out_valid;
    t_lines    r_lines;
    logic      r_implied;
    logic      r_push_pull;

    logic      out_load;
    logic      in_load;
    t_dec_ctrl ctrl;
    t_lines    lines;

    // Handshake: result register loads when empty or drained this cycle
    assign out_load = ~r_out_valid | ~i_stall;
    assign in_load  = ~r_in_valid | out_load;
    assign o_stall  = ~in_load;

    always_comb begin
        n_in_valid  = in_load ? i_valid : r_in_valid;
        n_out_valid = out_load ? r_in_valid : r_out_valid;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_ir        <= i_instr_byte;
            r_step      <= i_timing_step;
            r_not_ready <= i_prev_not_ready;
        end
    end

    cdp_col_gen u_col_gen (
        .i_ir        (r_ir),
        .i_step      (r_step),
        .i_not_ready (r_not_ready),
        .o_ctrl      (ctrl)
    );

    cdp_term_array u_term_array (
        .i_ctrl  (ctrl),
        .o_lines (lines)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_lines     <= lines;
            r_implied   <= ctrl.implied;
            r_push_pull <= ctrl.push_pull;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_lines_0_31     = r_lines[31:0];
    assign o_lines_32_63    = r_lines[63:32];
    assign o_lines_64_95    = r_lines[95:64];
    assign o_lines_96_127   = r_lines[127:96];
    assign o_implied_line   = r_implied;
    assign o_push_pull_line = r_push_pull;

endmodule

[rtl/cdp_checker.sv]
// Port-level checker for the decode PLA, bound to the top level.
`timescale 1ns / 1ps
module cdp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [31:0] o_lines_0_31,
    input  logic [31:0] o_lines_32_63,
    input  logic [31:0] o_lines_64_95,
    input  logic [31:0] o_lines_96_127,
    input  logic        o_implied_line,
    input  logic        o_push_pull_line
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid &&
            $stable(o_lines_0_31) && $stable(o_lines_32_63) &&
            $stable(o_lines_64_95) && $stable(o_lines_96_127) &&
            $stable(o_implied_line) && $stable(o_push_pull_line))
        else $error("stalled result changed");

    // Implied and push/pull detectors are exclusive
    a_detect_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_implied_line && o_push_pull_line))
        else $error("implied and push/pull both set");

    // Push/pull kills lines 83 and 90
    a_pp_kill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_push_pull_line |-> !o_lines_64_95[19] && !o_lines_64_95[26])
        else $error("excluded line set during push/pull");

    // Input side never stalls unless a result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with result side free");

endmodule

bind cpu_decode_pla cdp_checker u_cdp_checker (.*);
